### sv/rwm_pkg.sv
package rwm_pkg;

    localparam int MAX_RADIUS = 2;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_DEPTH  = WIN_SIDE * WIN_SIDE;
    localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
    localparam int RADIUS_W   = 2;
    localparam int KEY_W      = 24;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-3:0] REG_WINDOW_RADIUS = '0;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [RADIUS_W-1:0] t_radius;

    typedef struct packed {
        logic en;
        t_key key;
        t_cnt fill;
        t_cnt med_idx;
    } t_ins;

    function automatic t_cnt win_area(input t_radius radius);
        int r_eff;
        int side;
        begin
            r_eff = int'(radius);
            if (r_eff < 1) begin
                r_eff = 1;
            end
            if (r_eff > MAX_RADIUS) begin
                r_eff = MAX_RADIUS;
            end
            side = 2 * r_eff + 1;
            return t_cnt'(side * side);
        end
    endfunction

endpackage

### sv/rwm_cell.sv
module rwm_cell
    import rwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_key i_key,
    input  logic i_occ,
    input  t_key i_prev_key,
    input  logic i_prev_shift,
    output logic o_shift,
    output t_key o_key,
    output t_key o_next_key
);

    t_key r_key;
    t_key n_key;

    // occupied entry larger than the new pixel moves one place up
    assign o_shift = i_occ && (r_key > i_key);

    always_comb begin
        if (i_prev_shift) begin
            n_key = i_prev_key;
        end else if (o_shift || !i_occ) begin
            n_key = i_key;
        end else begin
            n_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= n_key;
        end
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule

### sv/rwm_sort_chain.sv
module rwm_sort_chain
    import rwm_pkg::*;
(
    input  logic i_clk,
    input  t_ins i_ins,
    output t_key o_med_key
);

    t_key w_key      [WIN_DEPTH];
    t_key w_next_key [WIN_DEPTH];
    logic w_shift    [WIN_DEPTH];

    for (genvar gi = 0; gi < WIN_DEPTH; gi++) begin : g_cell
        t_key w_prev_key;
        logic w_prev_shift;

        if (gi == 0) begin : g_head
            assign w_prev_key   = '0;
            assign w_prev_shift = 1'b0;
        end else begin : g_body
            assign w_prev_key   = w_key[gi-1];
            assign w_prev_shift = w_shift[gi-1];
        end

        rwm_cell u_cell (
            .i_clk        (i_clk),
            .i_en         (i_ins.en),
            .i_key        (i_ins.key),
            .i_occ        (t_cnt'(gi) < i_ins.fill),
            .i_prev_key   (w_prev_key),
            .i_prev_shift (w_prev_shift),
            .o_shift      (w_shift[gi]),
            .o_key        (w_key[gi]),
            .o_next_key   (w_next_key[gi])
        );
    end

    assign o_med_key = w_next_key[i_ins.med_idx];

endmodule

### sv/rgb_window_median_unit.sv
// Lexicographic (red, then green, then blue) median of a square window of
// RGB pixels. Pixels of one window enter one per clock in raster order via
// start; each is inserted into a 25-cell sorted chain in the cycle it is
// taken, so busy never rises and a pixel may be given every cycle. The
// window closes on the pixel that brings the count to (2r+1)^2 (9 or 25
// pixels); if the radius is lowered mid-window and the count already reaches
// the new area, the next pixel closes it and the median is taken over the
// pixels received so far. The median appears on the result ports with
// o_median_valid in the next cycle, for that one cycle only, and the next
// window may begin in the very next cycle. The receiver cannot stall and must
// take each result when it is strobed. window_radius (APB offset 0) treats 0
// as 1 and 3 as 2; write it only while no result is pending.
module rgb_window_median_unit
    import rwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [7:0]        i_pixel_red,
    input  logic [7:0]        i_pixel_green,
    input  logic [7:0]        i_pixel_blue,
    output logic              o_median_valid,
    output logic [7:0]        o_median_red,
    output logic [7:0]        o_median_green,
    output logic [7:0]        o_median_blue,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_radius r_radius;
    t_cnt    r_count;
    t_cnt    n_count;
    logic    r_valid;
    t_key    r_med;

    logic    w_take;
    logic    w_done;
    t_cnt    w_slot;
    t_cnt    w_num;
    t_ins    w_ins;
    t_key    w_med_key;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= t_radius'(1);
        end else if (psel && penable && pwrite && pready &&
                     paddr[APB_AW-1:2] == REG_WINDOW_RADIUS) begin
            r_radius <= pwdata[RADIUS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_WINDOW_RADIUS) begin
            prdata[RADIUS_W-1:0] = r_radius;
        end
    end

    always_comb begin
        w_slot  = (r_count >= t_cnt'(WIN_DEPTH - 1)) ? t_cnt'(WIN_DEPTH - 1) : r_count;
        w_num   = w_slot + t_cnt'(1);
        w_done  = w_num >= win_area(r_radius);
        n_count = w_done ? '0 : w_num;
    end

    assign w_ins.en      = w_take;
    assign w_ins.key     = {i_pixel_red, i_pixel_green, i_pixel_blue};
    assign w_ins.fill    = w_slot;
    assign w_ins.med_idx = w_num >> 1;

    rwm_sort_chain u_chain (
        .i_clk     (i_clk),
        .i_ins     (w_ins),
        .o_med_key (w_med_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_take && w_done;
            if (w_take) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_done) begin
            r_med <= w_med_key;
        end
    end

    assign o_median_valid = r_valid;
    assign o_median_red   = r_med[23:16];
    assign o_median_green = r_med[15:8];
    assign o_median_blue  = r_med[7:0];

`ifndef SYNTHESIS
    a_strobe_from_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_median_valid |-> $past(start && !busy))
        else $error("result without a pixel");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_median_valid |-> r_count == '0)
        else $error("count not cleared after window");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < t_cnt'(WIN_DEPTH))
        else $error("count beyond window depth");

    a_full_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && r_count == t_cnt'(WIN_DEPTH - 1)) |=> o_median_valid)
        else $error("full window did not close");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import rwm_pkg::*;

    localparam int RANDOM_PIXELS = 1500;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_GAP       = 13;

    typedef struct packed {
        logic    is_cfg;
        t_radius radius;
        t_key    px;
        logic    has_lit;
        t_key    lit;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        i_pixel_red;
    logic [7:0]        i_pixel_green;
    logic [7:0]        i_pixel_blue;
    logic              o_median_valid;
    logic [7:0]        o_median_red;
    logic [7:0]        o_median_green;
    logic [7:0]        o_median_blue;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    t_radius  radius_reg;
    t_key     window_pixels[$];
    t_key     pending_medians[$];
    t_key     want_px;
    t_dir_row directed_rows[$];
    int       errors;
    int       items_sent;
    int       medians_checked;
    int       radius_writes;
    int       cycle_count;

    rgb_window_median_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .o_median_valid (o_median_valid),
        .o_median_red   (o_median_red),
        .o_median_green (o_median_green),
        .o_median_blue  (o_median_blue),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: strobed for one cycle, compared against the oldest median
    always @(posedge i_clk) begin
        if (i_rst_n && o_median_valid) begin
            if (pending_medians.size() == 0) begin
                $display("%0t: unexpected median %02h_%02h_%02h", $time,
                         o_median_red, o_median_green, o_median_blue);
                errors++;
            end else begin
                want_px = pending_medians.pop_front();
                medians_checked++;
                if (o_median_red !== want_px[23:16]) begin
                    $display("%0t: median_red expected %02h actual %02h", $time,
                             want_px[23:16], o_median_red);
                    errors++;
                end
                if (o_median_green !== want_px[15:8]) begin
                    $display("%0t: median_green expected %02h actual %02h", $time,
                             want_px[15:8], o_median_green);
                    errors++;
                end
                if (o_median_blue !== want_px[7:0]) begin
                    $display("%0t: median_blue expected %02h actual %02h", $time,
                             want_px[7:0], o_median_blue);
                    errors++;
                end
            end
        end
    end

    // lexicographic median once the window (at the current radius) is full
    task automatic predict_pixel(input t_key px, output bit closed, output t_key med);
        int   r;
        int   area;
        int   n;
        int   i;
        int   j;
        t_key k;
        t_key sorted[WIN_DEPTH];
        begin
            r = int'(radius_reg);
            if (r < 1) r = 1;
            if (r > MAX_RADIUS) r = MAX_RADIUS;
            area = (2 * r + 1) * (2 * r + 1);
            window_pixels.push_back(px);
            n = window_pixels.size();
            closed = (n >= area);
            med = '0;
            if (closed) begin
                for (i = 0; i < n; i++) begin
                    k = window_pixels[i];
                    j = i;
                    while (j > 0 && sorted[j-1] > k) begin
                        sorted[j] = sorted[j-1];
                        j--;
                    end
                    sorted[j] = k;
                end
                med = sorted[n/2];
                window_pixels.delete();
            end
        end
    endtask

    task automatic send_pixel(input t_key px, input int gap, input bit has_lit,
                              input t_key lit);
        bit   closed;
        t_key med;
        begin
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            start         <= 1'b1;
            i_pixel_red   <= px[23:16];
            i_pixel_green <= px[15:8];
            i_pixel_blue  <= px[7:0];
            @(posedge i_clk);
            while (busy) @(posedge i_clk);
            items_sent++;
            predict_pixel(px, closed, med);
            if (closed) pending_medians.push_back(has_lit ? lit : med);
        end
    endtask

    task automatic apb_xfer(input bit wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= wr;
            paddr   <= {REG_WINDOW_RADIUS, 2'b00};
            pwdata  <= wdata;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            rdata = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // only once every median is out; partial windows may stay open
    task automatic set_radius(input t_radius r);
        logic [APB_DW-1:0] rd;
        begin
            start <= 1'b0;
            while (pending_medians.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            apb_xfer(1'b1, APB_DW'(r), rd);
            radius_reg = r;
            radius_writes++;
            apb_xfer(1'b0, '0, rd);
            if (rd !== APB_DW'(r)) begin
                $display("%0t: window_radius readback expected %0h actual %0h", $time,
                         APB_DW'(r), rd);
                errors++;
            end
        end
    endtask

    function automatic t_dir_row pix_row(input t_key px);
        return '{1'b0, t_radius'(0), px, 1'b0, t_key'(0)};
    endfunction

    function automatic t_dir_row lit_row(input t_key px, input t_key lit);
        return '{1'b0, t_radius'(0), px, 1'b1, lit};
    endfunction

    function automatic t_dir_row cfg_row(input t_radius r);
        return '{1'b1, r, t_key'(0), 1'b0, t_key'(0)};
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        int      phase;
        int      phase_len;
        int      k;
        int      random_sent;
        bit      burst;
        t_radius r;
        t_key    px;
        t_key    last_px;

        errors          = 0;
        items_sent      = 0;
        medians_checked = 0;
        radius_writes   = 0;
        cycle_count     = 0;
        radius_reg      = t_radius'(1);
        last_px         = '0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_pixel_red     <= '0;
        i_pixel_green   <= '0;
        i_pixel_blue    <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;

        // radius zero acts as one: nine pixels, five black beat four white
        directed_rows.push_back(cfg_row(t_radius'(0)));
        for (k = 0; k < 8; k++)
            directed_rows.push_back(pix_row(k[0] ? 24'hFFFFFF : 24'h000000));
        directed_rows.push_back(lit_row(24'h000000, 24'h000000));
        // radius three saturates to two, then shrinks to one after 12 pixels
        directed_rows.push_back(cfg_row(t_radius'(3)));
        directed_rows.push_back(pix_row(24'h00FFFF));
        directed_rows.push_back(pix_row(24'h010000));
        directed_rows.push_back(pix_row(24'h0000FF));
        directed_rows.push_back(pix_row(24'h00FF00));
        directed_rows.push_back(pix_row(24'hFF0000));
        directed_rows.push_back(pix_row(24'h000100));
        directed_rows.push_back(pix_row(24'h000001));
        directed_rows.push_back(pix_row(24'hFFFFFE));
        directed_rows.push_back(pix_row(24'h80FF00));
        directed_rows.push_back(pix_row(24'h807FFF));
        directed_rows.push_back(pix_row(24'h7FFFFF));
        directed_rows.push_back(pix_row(24'h010000));
        directed_rows.push_back(cfg_row(t_radius'(1)));
        directed_rows.push_back(pix_row(24'h7F7F7F));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                set_radius(directed_rows[i].radius);
            else
                send_pixel(directed_rows[i].px, $urandom_range(0, 2),
                           directed_rows[i].has_lit, directed_rows[i].lit);
        end

        // phases of whole and partial windows, radius changed in between
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            r = (phase < 4) ? t_radius'(phase) : t_radius'($urandom_range(0, 3));
            set_radius(r);
            burst     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 160);
            for (k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 7) == 0)
                    px = last_px;
                else
                    px = {rand_chan(), rand_chan(), rand_chan()};
                last_px = px;
                send_pixel(px, burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
                random_sent++;
            end
            phase++;
        end

        start <= 1'b0;
        while (pending_medians.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d pixels in %0d phases, %0d window_radius writes",
                 items_sent, phase, radius_writes);
        $display("%0d medians compared, %0d mismatches", medians_checked, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
sv/rwm_pkg.sv
sv/rwm_cell.sv
sv/rwm_sort_chain.sv
sv/rgb_window_median_unit.sv
tb/tb_top.sv
